// File: hw/rtl/ytb_pkg.sv
// Shared constants and types for the YUYV to BGR (BT.601) converter.
package ytb_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned FRAC_BITS = 20;
  localparam int unsigned LUMA_W    = 29;
  localparam int unsigned ACC_W     = 32;

  localparam logic [20:0]              COEF_Y     = 21'd1220542;
  localparam logic signed [ACC_W-1:0]  COEF_U_B   = 32'sd2116026;
  localparam logic signed [ACC_W-1:0]  COEF_U_G   = -32'sd409993;
  localparam logic signed [ACC_W-1:0]  COEF_V_G   = -32'sd852492;
  localparam logic signed [ACC_W-1:0]  COEF_V_R   = 32'sd1673527;
  localparam logic signed [ACC_W-1:0]  ROUND_HALF = 32'sd524288;
  localparam logic [PIX_W-1:0]         CHROMA_MID = 8'd128;
  localparam logic [PIX_W-1:0]         LUMA_FLOOR = 8'd16;

  typedef struct packed {
    logic signed [ACC_W-1:0] blue;
    logic signed [ACC_W-1:0] green;
    logic signed [ACC_W-1:0] red;
  } ytb_off_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } ytb_pix_t;

endpackage

// File: hw/rtl/ytb_if.sv
// Valid/ready channel interfaces for macropixel input and BGR pair output.
interface ytb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_first;
  logic [7:0] chroma_blue;
  logic [7:0] luma_second;
  logic [7:0] chroma_red;

  modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                  input ready);
  modport sink   (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                  output ready);
endinterface

interface ytb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_first;
  logic [7:0] green_first;
  logic [7:0] red_first;
  logic [7:0] blue_second;
  logic [7:0] green_second;
  logic [7:0] red_second;

  modport source (output valid, blue_first, green_first, red_first,
                  blue_second, green_second, red_second, input ready);
  modport sink   (input valid, blue_first, green_first, red_first,
                  blue_second, green_second, red_second, output ready);
endinterface

// File: hw/rtl/ytb_chroma.sv
// Shared chroma term: per-channel offsets from U and V, with rounding half, registered.
module ytb_chroma (
  input  logic                  clk,
  input  logic                  en,
  input  logic [7:0]            chroma_blue,
  input  logic [7:0]            chroma_red,
  output ytb_pkg::ytb_off_t     off
);
  import ytb_pkg::*;

  logic signed [8:0]       u_s;
  logic signed [8:0]       v_s;
  logic signed [ACC_W-1:0] u_ext;
  logic signed [ACC_W-1:0] v_ext;
  ytb_off_t                off_nxt;
  ytb_off_t                off_r;

  always_comb begin
    u_s = $signed({1'b0, chroma_blue}) - $signed({1'b0, CHROMA_MID});
    v_s = $signed({1'b0, chroma_red}) - $signed({1'b0, CHROMA_MID});
    u_ext = ACC_W'(u_s);
    v_ext = ACC_W'(v_s);
    off_nxt.blue  = ROUND_HALF + COEF_U_B * u_ext;
    off_nxt.green = ROUND_HALF + COEF_U_G * u_ext + COEF_V_G * v_ext;
    off_nxt.red   = ROUND_HALF + COEF_V_R * v_ext;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off_r <= off_nxt;
    end
  end

  assign off = off_r;
endmodule

// File: hw/rtl/ytb_lane.sv
// One pixel lane: scaled luma register, then three channel sums with clamp.
module ytb_lane (
  input  logic               clk,
  input  logic               en,
  input  logic [7:0]         luma,
  input  ytb_pkg::ytb_off_t  off,
  output ytb_pkg::ytb_pix_t  pix
);
  import ytb_pkg::*;

  logic [PIX_W-1:0]        luma_d;
  logic [LUMA_W-1:0]       ys_nxt;
  logic [LUMA_W-1:0]       ys_r;
  logic signed [ACC_W-1:0] ys_s;

  function automatic logic [PIX_W-1:0] clamp_ch(input logic signed [ACC_W-1:0] acc);
    logic [PIX_W-1:0] res;
    if (acc[ACC_W-1]) begin
      res = '0;
    end else if (|acc[ACC_W-2:FRAC_BITS+PIX_W]) begin
      res = '1;
    end else begin
      res = acc[FRAC_BITS+PIX_W-1:FRAC_BITS];
    end
    return res;
  endfunction

  always_comb begin
    luma_d = (luma >= LUMA_FLOOR) ? (luma - LUMA_FLOOR) : '0;
    ys_nxt = LUMA_W'(luma_d) * LUMA_W'(COEF_Y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ys_r <= ys_nxt;
    end
  end

  always_comb begin
    ys_s      = $signed({{(ACC_W-LUMA_W){1'b0}}, ys_r});
    pix.blue  = clamp_ch(ys_s + off.blue);
    pix.green = clamp_ch(ys_s + off.green);
    pix.red   = clamp_ch(ys_s + off.red);
  end
endmodule

// File: hw/rtl/yuyv_to_bgr_bt601.sv
// Top level: YUYV 4:2:2 macropixel to two BGR pixels, BT.601, 20-bit fixed point.
//
// Input channel in_ch carries one macropixel (Y0, U, Y1, V) per transaction;
// output channel out_ch carries the two resulting BGR pixels per transaction.
// Both use valid/ready; a transaction completes when both are high at a clock edge.
//
// Pipeline: stage 1 registers the scaled luma of each lane and the shared
// chroma offsets (one multiplier per term); stage 2 adds, shifts, clamps and
// lands in the output register, from which out_ch.valid is driven. Throughput
// is one macropixel per cycle while the receiver does not stall, set by the
// two pixel lanes and the chroma unit working in parallel on every transaction.
//
// Reset (rst_n low, synchronous) empties both stages by clearing their valid
// flags; the data registers are not reset. When the receiver stalls, the output
// register holds its result and the stage in front keeps filling, so up to two
// transactions sit in the block before in_ch.ready drops.
module yuyv_to_bgr_bt601 (
  input  logic      clk,
  input  logic      rst_n,
  ytb_in_if.sink    in_ch,
  ytb_out_if.source out_ch
);
  import ytb_pkg::*;

  logic     v1_r;
  logic     v1_nxt;
  logic     out_valid_r;
  logic     out_valid_nxt;
  logic     en1;
  logic     en2;
  ytb_off_t off;
  ytb_pix_t pix_first;
  ytb_pix_t pix_second;
  ytb_pix_t first_r;
  ytb_pix_t second_r;

  assign en2 = !out_valid_r || out_ch.ready;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  ytb_chroma u_chroma (
    .clk         (clk),
    .en          (en1),
    .chroma_blue (in_ch.chroma_blue),
    .chroma_red  (in_ch.chroma_red),
    .off         (off)
  );

  ytb_lane u_lane_first (
    .clk  (clk),
    .en   (en1),
    .luma (in_ch.luma_first),
    .off  (off),
    .pix  (pix_first)
  );

  ytb_lane u_lane_second (
    .clk  (clk),
    .en   (en1),
    .luma (in_ch.luma_second),
    .off  (off),
    .pix  (pix_second)
  );

  always_comb begin
    v1_nxt        = en1 ? in_ch.valid : v1_r;
    out_valid_nxt = en2 ? v1_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // merge the two lanes into the output register
  always_ff @(posedge clk) begin
    if (en2) begin
      first_r  <= pix_first;
      second_r <= pix_second;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.blue_first   = first_r.blue;
  assign out_ch.green_first  = first_r.green;
  assign out_ch.red_first    = first_r.red;
  assign out_ch.blue_second  = second_r.blue;
  assign out_ch.green_second = second_r.green;
  assign out_ch.red_second   = second_r.red;

  a_in_to_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v1_r)
    else $error("accepted transaction did not reach stage 1");

  a_stage1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && en2) |=> out_ch.valid)
    else $error("stage 1 transaction did not reach output register");

  a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v1_r && out_ch.valid && !out_ch.ready))
    else $error("input stalled while pipeline has room");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!v1_r && out_ch.valid && out_ch.ready) |=> !out_ch.valid)
    else $error("output transaction repeated");

endmodule

// File: bench/ytb_conv_checker.sv
// Checker for the YUYV to BGR converter: predicts each pixel pair and compares.
module ytb_conv_checker (
  input  logic clk,
  input  logic rst_n,
  ytb_in_if    in_ch,
  ytb_out_if   out_ch,
  output int   failures,
  output int   pending
);
  import ytb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [5:0][PIX_W-1:0] bgr_pair_t;

  bgr_pair_t expected_pairs[$];
  string     field_name[6] = '{"red_second", "green_second", "blue_second",
                               "red_first", "green_first", "blue_first"};

  function automatic logic [PIX_W-1:0] saturate(longint acc);
    longint q;
    if (acc < 0) return '0;
    q = acc >> FRAC_BITS;
    return (q > 255) ? 8'd255 : q[PIX_W-1:0];
  endfunction

  function automatic longint luma_term(logic [PIX_W-1:0] y);
    longint d;
    d = longint'(y) - longint'(LUMA_FLOOR);
    if (d < 0) d = 0;
    return d * longint'(COEF_Y);
  endfunction

  function automatic bgr_pair_t convert_macropixel(logic [PIX_W-1:0] y0, u, y1, v);
    longint cu, cv, off_b, off_g, off_r, ys0, ys1;
    cu    = longint'(u) - longint'(CHROMA_MID);
    cv    = longint'(v) - longint'(CHROMA_MID);
    off_b = longint'(ROUND_HALF) + longint'(COEF_U_B) * cu;
    off_g = longint'(ROUND_HALF) + longint'(COEF_U_G) * cu + longint'(COEF_V_G) * cv;
    off_r = longint'(ROUND_HALF) + longint'(COEF_V_R) * cv;
    ys0   = luma_term(y0);
    ys1   = luma_term(y1);
    return {saturate(ys0 + off_b), saturate(ys0 + off_g), saturate(ys0 + off_r),
            saturate(ys1 + off_b), saturate(ys1 + off_g), saturate(ys1 + off_r)};
  endfunction

  task automatic report(string msg);
    $display("[%0t] checker: %s", $time, msg);
    failures++;
  endtask

  always @(posedge clk) begin : watch
    bgr_pair_t got, want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.blue_first, out_ch.green_first, out_ch.red_first,
               out_ch.blue_second, out_ch.green_second, out_ch.red_second};
        if (expected_pairs.size() == 0) begin
          report($sformatf("result transaction with nothing expected: %h", got));
        end else begin
          want = expected_pairs.pop_front();
          for (int i = 0; i < 6; i++) begin
            if (got[i] !== want[i])
              report($sformatf("%s got %0d, want %0d", field_name[i], got[i], want[i]));
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_pairs.push_back(convert_macropixel(in_ch.luma_first, in_ch.chroma_blue,
                                                    in_ch.luma_second, in_ch.chroma_red));
    end
    pending <= expected_pairs.size();
  end

endmodule

// File: bench/yuyv_to_bgr_bt601_test.sv
// Testbench top for yuyv_to_bgr_bt601: clock, reset, macropixel stimulus and verdict.
module yuyv_to_bgr_bt601_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic steady = 1'b0;
  int   failures;
  int   pending;
  int   cycle_count = 0;

  ytb_in_if  in_ch ();
  ytb_out_if out_ch ();

  yuyv_to_bgr_bt601 uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ytb_conv_checker checker_i (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .failures (failures),
    .pending  (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 13);
  end

  function automatic logic [7:0] pick_byte();
    logic [7:0] corners[10] = '{8'd0, 8'd15, 8'd16, 8'd17, 8'd127,
                                8'd128, 8'd129, 8'd235, 8'd240, 8'd255};
    if ($urandom_range(99) < 20) return corners[$urandom_range(9)];
    return 8'($urandom_range(255));
  endfunction

  task automatic send_macropixel(logic [7:0] y0, u, y1, v);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.luma_first  <= y0;
    in_ch.chroma_blue <= u;
    in_ch.luma_second <= y1;
    in_ch.chroma_red  <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.luma_first  = '0;
    in_ch.chroma_blue = '0;
    in_ch.luma_second = '0;
    in_ch.chroma_red  = '0;
    out_ch.ready      = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // corners: luma floor, chroma extremes, saturation both ways
    send_macropixel(8'd0,   8'd0,   8'd0,   8'd0);
    send_macropixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_macropixel(8'd16,  8'd128, 8'd16,  8'd128);
    send_macropixel(8'd15,  8'd128, 8'd0,   8'd128);
    send_macropixel(8'd17,  8'd128, 8'd235, 8'd128);
    send_macropixel(8'd235, 8'd128, 8'd255, 8'd128);
    send_macropixel(8'd128, 8'd0,   8'd128, 8'd128);
    send_macropixel(8'd128, 8'd255, 8'd128, 8'd128);
    send_macropixel(8'd128, 8'd128, 8'd128, 8'd0);
    send_macropixel(8'd128, 8'd128, 8'd128, 8'd255);
    send_macropixel(8'd0,   8'd0,   8'd255, 8'd0);
    send_macropixel(8'd255, 8'd0,   8'd0,   8'd255);
    send_macropixel(8'd0,   8'd255, 8'd255, 8'd0);
    send_macropixel(8'd255, 8'd255, 8'd0,   8'd255);
    send_macropixel(8'd16,  8'd0,   8'd16,  8'd0);
    send_macropixel(8'd16,  8'd255, 8'd16,  8'd255);
    send_macropixel(8'd235, 8'd240, 8'd235, 8'd240);
    send_macropixel(8'd235, 8'd16,  8'd235, 8'd16);
    send_macropixel(8'd81,  8'd90,  8'd145, 8'd240);
    send_macropixel(8'd170, 8'd166, 8'd41,  8'd110);
    send_macropixel(8'h55,  8'hAA,  8'hAA,  8'h55);
    send_macropixel(8'hAA,  8'h55,  8'h55,  8'hAA);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 600) steady <= 1'b1;
      if (n == 900) steady <= 1'b0;
      if (n == 1200) drain_results();
      send_macropixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (failures == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
